// File: hdl/bmp_pkg.sv
package bmp_pkg;

    localparam int CFG_DIM_W   = 13;
    localparam int CFG_BS_W    = 8;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_ADDR_W  = 2;
    localparam int ROW_W       = 12;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COLOUR_W    = 24;

    localparam int MID_DEPTH   = 4;
    localparam int OUT_DEPTH   = 4;
    localparam int CAPACITY    = MID_DEPTH + OUT_DEPTH + 1;
    localparam int INFLIGHT_W  = $clog2(CAPACITY + 1);

    localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [CFG_BS_W-1:0]  RST_BLOCK_SIZE   = 8'd20;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_BLOCK_SIZE   = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_STORE = 2'd1,
        OP_FETCH = 2'd2
    } t_op;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] frame_width;
        logic [CFG_DIM_W-1:0] frame_height;
        logic [CFG_BS_W-1:0]  block_size;
    } t_cfg;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_pixel_out;

    typedef struct packed {
        t_op                 op;
        logic [COLOUR_W-1:0] colour;
    } t_cmd;

endpackage

// File: hdl/block_mosaic_pixelator.sv
// Block mosaic pixelator: replaces each complete square block of a raster RGB
// stream with the colour of the block's top-left pixel.
// Input channel: push/full queue carrying i_pixel (frame_start + RGB). A
// transfer happens on a clock edge with push high and full low.
// Result channel: empty/pop queue; o_pixel shows the oldest result while
// empty is low, and it is transferred on an edge with pop high.
// Config: write i_cfg_data to register i_cfg_addr (0 width, 1 height,
// 2 block size) while i_cfg_we is high; only while the block is idle.
// Results pass the middle queue, the memory stage and the output queue.
// Throughput: one pixel per clock while pop keeps up; set by the single-port
// block colour memory, which serves one store or one fetch per cycle.
// Reset (synchronous, active low): position counters clear, queues empty,
// registers go to 640 x 480 with block size 20. The colour memory is not
// cleared; every fetch follows the store of its block's first row.
// Receiver stall: up to four results wait in the output queue, four
// commands in the middle queue; full rises once both are taken up.
module block_mosaic_pixelator #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bmp_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [bmp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  bmp_pkg::t_pixel_in                i_pixel,
    output logic                              empty,
    input  logic                              pop,
    output bmp_pkg::t_pixel_out               o_pixel
);

    import bmp_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int MID_W = $bits(t_cmd) + AW;

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= RST_FRAME_WIDTH;
            r_cfg.frame_height <= RST_FRAME_HEIGHT;
            r_cfg.block_size   <= RST_BLOCK_SIZE;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data[CFG_DIM_W-1:0];
                REG_BLOCK_SIZE:   r_cfg.block_size   <= i_cfg_data[CFG_BS_W-1:0];
                default: ;
            endcase
        end
    end

    logic             in_xfer;
    logic             out_xfer;
    t_cmd             front_cmd;
    logic [AW-1:0]    front_idx;
    logic [MID_W-1:0] mid_rdata;
    logic             mid_empty;
    logic             back_take;

    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;

    // front: track position, classify each pixel as pass, store or fetch
    bmp_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (in_xfer),
        .i_pixel (i_pixel),
        .o_cmd   (front_cmd),
        .o_idx   (front_idx)
    );

    // decoupling queue; its full flag is the input back-pressure
    bmp_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_cmd, front_idx}),
        .o_full  (full),
        .i_pop   (back_take),
        .o_empty (mid_empty),
        .o_data  (mid_rdata),
        .o_count ()
    );

    // back: colour memory access and the result queue
    bmp_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!mid_empty),
        .i_cmd   (t_cmd'(mid_rdata[MID_W-1:AW])),
        .i_idx   (mid_rdata[AW-1:0]),
        .o_take  (back_take),
        .o_empty (empty),
        .i_pop   (pop),
        .o_pixel (o_pixel)
    );

    // pixels inside the block, used for the checks below
    logic [INFLIGHT_W-1:0] r_inflight, n_inflight;

    assign n_inflight = r_inflight + INFLIGHT_W'(in_xfer) - INFLIGHT_W'(out_xfer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not idle after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_inflight == '0) |-> ##3 !empty)
        else $error("result did not appear two cycles after transfer");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_inflight != '0))
        else $error("result offered with no pixel outstanding");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= INFLIGHT_W'(CAPACITY))
        else $error("more pixels held than the queues can take");

endmodule

// File: hdl/bmp_fifo.sv
module bmp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign o_count = r_count;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_count  = r_count + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/bmp_front.sv
module bmp_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bmp_pkg::t_cfg                  i_cfg,
    input  logic                           i_valid,
    input  bmp_pkg::t_pixel_in             i_pixel,
    output bmp_pkg::t_cmd                  o_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_idx
);

    import bmp_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int SW  = ((WW > CFG_DIM_W) ? WW : CFG_DIM_W) + 2;
    localparam int RSW = CFG_DIM_W + 2;

    logic [AW-1:0]       r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [CFG_BS_W-1:0] r_col_ph, n_col_ph;
    logic [CFG_BS_W-1:0] r_row_ph, n_row_ph;
    logic [AW-1:0]       r_bidx, n_bidx;

    logic [AW-1:0]       col;
    logic [ROW_W-1:0]    row;
    logic [CFG_BS_W-1:0] col_ph, row_ph;
    logic [AW-1:0]       bidx;
    logic [SW-1:0]       eff_w, col_s, cph_s, cstart, col_inc;
    logic [RSW-1:0]      eff_h, row_s, rph_s, rstart, row_inc;
    logic [CFG_BS_W:0]   cph_inc, rph_inc;
    logic                col_full, row_full, bs_zero;

    always_comb begin
        // zero dimensions act as one, oversize ones clip to the maximum
        if (i_cfg.frame_width == '0) begin
            eff_w = SW'(1);
        end else if (SW'(i_cfg.frame_width) > SW'(MAX_WIDTH)) begin
            eff_w = SW'(MAX_WIDTH);
        end else begin
            eff_w = SW'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height == '0) begin
            eff_h = RSW'(1);
        end else if (RSW'(i_cfg.frame_height) > RSW'(MAX_HEIGHT)) begin
            eff_h = RSW'(MAX_HEIGHT);
        end else begin
            eff_h = RSW'(i_cfg.frame_height);
        end

        if (i_pixel.frame_start) begin
            col    = '0;
            row    = '0;
            col_ph = '0;
            row_ph = '0;
            bidx   = '0;
        end else begin
            col    = r_col;
            row    = r_row;
            col_ph = r_col_ph;
            row_ph = r_row_ph;
            bidx   = r_bidx;
        end

        bs_zero  = (i_cfg.block_size == '0);
        col_s    = SW'(col);
        cph_s    = SW'(col_ph);
        cstart   = (col_s >= cph_s) ? col_s - cph_s : '0;
        row_s    = RSW'(row);
        rph_s    = RSW'(row_ph);
        rstart   = (row_s >= rph_s) ? row_s - rph_s : '0;
        col_full = !bs_zero && (cstart + SW'(i_cfg.block_size) <= eff_w);
        row_full = !bs_zero && (rstart + RSW'(i_cfg.block_size) <= eff_h);

        o_cmd.colour = {i_pixel.red_in, i_pixel.green_in, i_pixel.blue_in};
        o_idx        = bidx;
        if (col_full && row_full) begin
            o_cmd.op = (col_ph == '0 && row_ph == '0) ? OP_STORE : OP_FETCH;
        end else begin
            o_cmd.op = OP_PASS;
        end

        // position advance
        col_inc  = col_s + SW'(1);
        row_inc  = row_s + RSW'(1);
        cph_inc  = {1'b0, col_ph} + 9'd1;
        rph_inc  = {1'b0, row_ph} + 9'd1;
        n_col    = col;
        n_row    = row;
        n_col_ph = col_ph;
        n_row_ph = row_ph;
        n_bidx   = bidx;
        if (col_inc >= eff_w) begin
            n_col    = '0;
            n_col_ph = '0;
            n_bidx   = '0;
            if (row_inc >= eff_h) begin
                n_row    = '0;
                n_row_ph = '0;
            end else begin
                n_row    = row_inc[ROW_W-1:0];
                n_row_ph = (rph_inc >= {1'b0, i_cfg.block_size}) ?
                           '0 : rph_inc[CFG_BS_W-1:0];
            end
        end else begin
            n_col = col_inc[AW-1:0];
            if (cph_inc >= {1'b0, i_cfg.block_size}) begin
                n_col_ph = '0;
                n_bidx   = bidx + AW'(1);
            end else begin
                n_col_ph = cph_inc[CFG_BS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_col_ph <= '0;
            r_row_ph <= '0;
            r_bidx   <= '0;
        end else if (i_valid) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_col_ph <= n_col_ph;
            r_row_ph <= n_row_ph;
            r_bidx   <= n_bidx;
        end
    end

endmodule

// File: hdl/bmp_back.sv
module bmp_back #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  bmp_pkg::t_cmd                  i_cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_idx,
    output logic                           o_take,
    output logic                           o_empty,
    input  logic                           i_pop,
    output bmp_pkg::t_pixel_out            o_pixel
);

    import bmp_pkg::*;

    localparam int OCW = $clog2(OUT_DEPTH + 1);

    logic [COLOUR_W-1:0] r_mem [MAX_WIDTH];
    logic [COLOUR_W-1:0] r_rd_data;
    logic                r_s1_valid;
    t_op                 r_s1_op;
    logic [COLOUR_W-1:0] r_s1_colour;
    logic [COLOUR_W-1:0] result;
    logic [OCW-1:0]      out_count;

    // take a command only if the output queue has room for it and the one in flight
    assign o_take = i_valid &&
                    ({1'b0, out_count} + (OCW+1)'(r_s1_valid) < (OCW+1)'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (o_take && i_cmd.op == OP_STORE) begin
            r_mem[i_idx] <= i_cmd.colour;
        end
        if (o_take && i_cmd.op == OP_FETCH) begin
            r_rd_data <= r_mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_s1_op     <= i_cmd.op;
            r_s1_colour <= i_cmd.colour;
        end
    end

    assign result = (r_s1_op == OP_FETCH) ? r_rd_data : r_s1_colour;

    // credit check keeps the queue from ever being pushed while full
    bmp_fifo #(
        .WIDTH ($bits(t_pixel_out)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (result),
        .o_full  (),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (o_pixel),
        .o_count (out_count)
    );

endmodule
